/* sv/rsm_pkg.sv */
package rsm_pkg;

  localparam int unsigned RowLen = 32;
  localparam int unsigned IdxW = $clog2(RowLen);
  localparam int unsigned CntW = $clog2(RowLen + 1);
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef struct packed {
    logic signed [15:0] logit;
    logic               row_end;
  } req_t;

  typedef struct packed {
    logic [16:0] prob;
    logic [5:0]  position;
    logic        last_out;
    logic        truncated;
  } rsp_t;

  // classified element as queued between front and back
  typedef struct packed {
    logic signed [15:0] logit;
    logic               row_end;
    logic               keep;
  } elem_t;

  // fraction table 2^(-f/256) in q1.16, built from a q30 product
  function automatic logic [16:0] frac_val(input logic [7:0] f);
    logic [63:0] a;
    logic [63:0] c [8];
    c[0] = 64'd1070838486; c[1] = 64'd1067942999; c[2] = 64'd1062175491;
    c[3] = 64'd1050733750; c[4] = 64'd1028218691; c[5] = 64'd984625594;
    c[6] = 64'd902905624;  c[7] = 64'd759250125;
    a = 64'd1073741824;
    for (int k = 0; k < 8; k++) begin
      if (f[k]) a = (a * c[k] + 64'd536870912) >> 30;
    end
    a = (a + 64'd8192) >> 14;
    return a[16:0];
  endfunction

endpackage

/* sv/rsm_front.sv */
module rsm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rsm_pkg::req_t req_i,
  input  logic          q_full_i,
  output logic          busy_o,
  output logic          push_o,
  output rsm_pkg::elem_t push_data_o
);

  logic [rsm_pkg::CntW-1:0] cnt_d, cnt_q;

  // a full queue holds off requests
  assign busy_o = q_full_i;
  assign push_o = start_i && !q_full_i;

  // classify: keep while the row has room
  assign push_data_o.logit   = req_i.logit;
  assign push_data_o.row_end = req_i.row_end;
  assign push_data_o.keep    = (cnt_q < rsm_pkg::CntW'(rsm_pkg::RowLen));

  // per-row element counter
  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      if (req_i.row_end) cnt_d = '0;
      else if (push_data_o.keep) cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

endmodule

/* sv/rsm_queue.sv */
module rsm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rsm_pkg::elem_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output rsm_pkg::elem_t pop_data_o
);

  rsm_pkg::elem_t mem_q [rsm_pkg::QDepth];
  logic [rsm_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [rsm_pkg::QPtrW:0]   n_q;

  assign full_o     = (n_q == (rsm_pkg::QPtrW+1)'(rsm_pkg::QDepth));
  assign empty_o    = (n_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; n_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      n_q <= n_q + (rsm_pkg::QPtrW+1)'(push_i) - (rsm_pkg::QPtrW+1)'(pop_i);
    end
  end

endmodule

/* sv/rsm_back.sv */
module rsm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  rsm_pkg::elem_t q_data_i,
  output logic           pop_o,
  output logic           res_valid_o,
  output rsm_pkg::rsp_t  res_o
);

  typedef enum logic [7:0] {
    SLoad  = 8'b00000001,
    SExpRd = 8'b00000010,
    SExpMl = 8'b00000100,
    SExpWr = 8'b00001000,
    SDivRd = 8'b00010000,
    SDivIn = 8'b00100000,
    SDiv   = 8'b01000000,
    SOut   = 8'b10000000
  } state_e;

  localparam int unsigned IW = rsm_pkg::IdxW;
  localparam int unsigned CW = rsm_pkg::CntW;

  state_e state_d, state_q;
  logic signed [15:0] row_mem [rsm_pkg::RowLen];
  logic [16:0]        exp_mem [rsm_pkg::RowLen];
  logic signed [15:0] max_q;
  logic [CW-1:0]      fill_q, idx_q;
  logic [22:0]        sum_q;
  logic               ovf_q;
  logic signed [15:0] rd_x_q;
  logic [16:0]        rd_e_q;
  logic [15:0]        m_diff;
  logic [16:0]        t_q;
  logic [8:0]         ip;
  logic [16:0]        frac;
  logic [16:0]        frac_tab [256];
  logic [16:0]        e_val;
  logic [39:0]        rem_q;
  logic [16:0]        quo_q;
  logic [5:0]         bit_q;
  logic [39:0]        trial;
  logic [IW-1:0]      idx_a;

  assign idx_a = idx_q[IW-1:0];
  assign pop_o = (state_q == SLoad) && !q_empty_i;

  // constant fraction table
  for (genvar g = 0; g < 256; g++) begin : g_frac
    assign frac_tab[g] = rsm_pkg::frac_val(8'(g));
  end

  // distance below the row maximum, wraps at 16 bits
  assign m_diff = 16'(max_q - rd_x_q);

  // exponential from the registered product
  always_comb begin
    ip   = t_q[16:8];
    frac = frac_tab[t_q[7:0]];
    if (ip == 9'd0) e_val = frac;
    else if (ip >= 9'd17) e_val = '0;
    else e_val = 17'((({1'b0, frac} + (18'd1 << (ip - 9'd1))) >> ip));
  end

  assign trial = rem_q - ({17'd0, sum_q} << bit_q);

  // control
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SLoad:  if (pop_o && q_data_i.row_end) state_d = SExpRd;
      SExpRd: state_d = SExpMl;
      SExpMl: state_d = SExpWr;
      SExpWr: state_d = (idx_q + 1'b1 == fill_q) ? SDivRd : SExpRd;
      SDivRd: state_d = SDivIn;
      SDivIn: state_d = SDiv;
      SDiv:   if (bit_q == 6'd0) state_d = SOut;
      SOut:   state_d = (idx_q + 1'b1 == fill_q) ? SLoad : SDivRd;
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SLoad; max_q <= 16'sh8000; fill_q <= '0; idx_q <= '0;
      sum_q <= '0; ovf_q <= 1'b0; res_valid_o <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_o <= 1'b0;
      unique case (state_q)
        SLoad: if (pop_o) begin
          if (q_data_i.keep) begin
            fill_q <= fill_q + 1'b1;
            if (q_data_i.logit > max_q) max_q <= q_data_i.logit;
          end else ovf_q <= 1'b1;
          idx_q <= '0; sum_q <= '0;
        end
        SExpWr: begin
          sum_q <= sum_q + {6'd0, e_val};
          idx_q <= (idx_q + 1'b1 == fill_q) ? '0 : idx_q + 1'b1;
        end
        SOut: begin
          res_valid_o <= 1'b1;
          if (idx_q + 1'b1 == fill_q) begin
            idx_q <= '0; fill_q <= '0; max_q <= 16'sh8000; ovf_q <= 1'b0;
          end else idx_q <= idx_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // datapath, stores and divider
  always_ff @(posedge clk_i) begin
    if (pop_o && q_data_i.keep) row_mem[fill_q[IW-1:0]] <= q_data_i.logit;
    rd_x_q <= row_mem[idx_a];
    rd_e_q <= exp_mem[idx_a];
    if (state_q == SExpMl) t_q <= 17'(({17'd0, m_diff} * 33'd94548 + 33'd32768) >> 16);
    if (state_q == SExpWr) exp_mem[idx_a] <= e_val;
    if (state_q == SDivIn) begin
      rem_q <= {7'd0, rd_e_q, 16'd0} + {18'd0, sum_q[22:1]};
      quo_q <= '0;
      bit_q <= 6'd16;
    end
    if (state_q == SDiv) begin
      if (!trial[39] && (rem_q >= ({17'd0, sum_q} << bit_q))) begin
        rem_q <= trial;
        quo_q <= quo_q | (17'd1 << bit_q);
      end
      if (bit_q != 6'd0) bit_q <= bit_q - 1'b1;
    end
    if (state_q == SOut) begin
      res_o.prob      <= quo_q;
      res_o.position  <= 6'(idx_q);
      res_o.last_out  <= (idx_q + 1'b1 == fill_q);
      res_o.truncated <= ovf_q;
    end
  end

endmodule

/* sv/row_softmax.sv */
// channel  | ports                      | handshake
// request  | start, req_i, busy         | taken when start && !busy
// result   | res_valid_o, res_o         | one cycle strobe, no backpressure
// a request enters a 4-deep queue; the back end loads one per cycle while
// idle and the queue is not empty. on row end it runs exp on each element
// (read, multiply, write), then a bit-serial divide and output per element.
// busy rises only when the queue is full while the back end works a row.
// the receiver cannot stall; reset is asynchronous, active low, clears row state.
module row_softmax (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rsm_pkg::req_t req_i,
  output logic          busy,
  output logic          res_valid_o,
  output rsm_pkg::rsp_t res_o
);

  logic           push, pop, full, empty;
  rsm_pkg::elem_t push_data, pop_data;

  rsm_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .q_full_i(full),
    .busy_o(busy), .push_o(push), .push_data_o(push_data)
  );

  rsm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .pop_i(pop),
    .full_o(full), .empty_o(empty), .pop_data_o(pop_data)
  );

  rsm_back u_back (
    .clk_i, .rst_ni, .q_empty_i(empty), .q_data_i(pop_data), .pop_o(pop),
    .res_valid_o, .res_o
  );

endmodule
